// ----- design/ncrf_pkg.sv -----
// shared types, widths and constants for the newton cubic root finder
`default_nettype none

package ncrf_pkg;

	// word and datapath widths
	localparam int unsigned DATA_W    = 32;
	localparam int unsigned STEPS_W   = 8;
	localparam int unsigned TOL_W     = 31;
	localparam int unsigned WIDE_W    = 128;
	localparam int unsigned LIMB_W    = 32;
	localparam int unsigned LIMBS     = WIDE_W / LIMB_W;
	localparam int unsigned LIMB_IDX_W = $clog2(LIMBS);

	// quotient is only needed up to the correction clamp
	localparam int unsigned CORR_LOG2 = 40;
	localparam int unsigned QUO_W     = CORR_LOG2 + 2;
	localparam int unsigned CNT_W     = $clog2(QUO_W);
	localparam logic [QUO_W-1:0] CORR_LIM = QUO_W'(1) << CORR_LOG2;

	// stream word layout
	localparam int unsigned S_TDATA_W = 32;
	localparam int unsigned M_TDATA_W = 40;

	// configuration port
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned APB_ADDR_W = 3;
	localparam logic REG_TOLERANCE = 1'b0;
	localparam logic REG_ITER_LIMIT = 1'b1;

	localparam logic [TOL_W-1:0]   TOLERANCE_RESET = TOL_W'(66);
	localparam logic [STEPS_W-1:0] LIMIT_RESET     = STEPS_W'(100);

	localparam int unsigned FRAC_BITS_DEF = 16;

	// coefficients of f and f'
	localparam int unsigned CUBIC_SQ_COEF  = 2;
	localparam int unsigned CUBIC_LIN_COEF = 10;
	localparam int unsigned CUBIC_CONST    = 20;
	localparam int unsigned DERIV_SQ_COEF  = 3;
	localparam int unsigned DERIV_LIN_COEF = 4;
	localparam int unsigned DERIV_CONST    = 10;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP,
		ST_MUL_T,
		ST_MUL_N,
		ST_MUL_D,
		ST_DIV,
		ST_UPDATE,
		ST_DONE
	} ncrf_state_t;

	// coef * 2^(frac*pw) as a wide two's complement constant
	function automatic logic [WIDE_W-1:0] scaled_const(int unsigned frac, int unsigned pw,
			int unsigned coef);
		logic [WIDE_W-1:0] v;
		v = WIDE_W'(coef) << (frac * pw);
		return v;
	endfunction

endpackage

`default_nettype wire

// ----- design/newton_cubic_root_finder_core.sv -----
// top level: newton-raphson root finder for x^3+2x^2+10x-20 in signed fixed point
// per step: a launch state, three 4-limb multiply-accumulates on one 33x33 multiplier,
//   a restoring divide, then an update state
// throughput: one word at a time, the next word is taken once the result is in the output register
// reset: arst_n clears the sequencer and output valid, tolerance returns to 66, limit to 100
`default_nettype none

module newton_cubic_root_finder_core #(
	parameter int unsigned FRAC_BITS = ncrf_pkg::FRAC_BITS_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// input stream; s_tdata: start_point[31:0]
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	input  wire  [ncrf_pkg::S_TDATA_W-1:0]      s_tdata,
	// result stream; m_tdata: root_estimate[31:0], steps_taken[39:32]
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	output logic [ncrf_pkg::M_TDATA_W-1:0]      m_tdata,
	// m_tuser: converged[0]
	output logic                                m_tuser,
	// configuration port
	input  wire                                 psel,
	input  wire                                 penable,
	input  wire                                 pwrite,
	input  wire  [ncrf_pkg::APB_ADDR_W-1:0]     paddr,
	input  wire  [ncrf_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [ncrf_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready
);

	localparam int unsigned DW = ncrf_pkg::DATA_W;
	localparam int unsigned WW = ncrf_pkg::WIDE_W;
	localparam int unsigned QW = ncrf_pkg::QUO_W;
	localparam int unsigned SW = ncrf_pkg::STEPS_W;
	localparam int unsigned TW = ncrf_pkg::TOL_W;
	localparam int unsigned CORR_W = QW;        // signed correction
	localparam int unsigned DIFF_W = QW + 1;    // estimate minus correction

	// constant terms of the horner forms, scaled by 2^FRAC_BITS powers
	localparam logic [WW-1:0] K_T_LIN   =
		ncrf_pkg::scaled_const(FRAC_BITS, 1, ncrf_pkg::CUBIC_SQ_COEF);
	localparam logic [WW-1:0] K_T_CONST =
		ncrf_pkg::scaled_const(FRAC_BITS, 2, ncrf_pkg::CUBIC_LIN_COEF);
	localparam logic [WW-1:0] K_N_CONST = WW'(0) -
		ncrf_pkg::scaled_const(FRAC_BITS, 3, ncrf_pkg::CUBIC_CONST);
	localparam logic [WW-1:0] K_D_LIN   =
		ncrf_pkg::scaled_const(FRAC_BITS, 1, ncrf_pkg::DERIV_LIN_COEF);
	localparam logic [WW-1:0] K_D_CONST =
		ncrf_pkg::scaled_const(FRAC_BITS, 2, ncrf_pkg::DERIV_CONST);

	ncrf_pkg::ncrf_state_t state_q, state_nx;

	// configuration registers
	logic [TW-1:0] tol_q;
	logic [SW-1:0] limit_q;

	// working registers
	logic [DW-1:0] x_q;        // current estimate x0
	logic [DW-1:0] x1_q;       // estimate after this step
	logic [WW-1:0] n_q;        // numerator f(x) scaled
	logic [SW-1:0] steps_q;
	logic          conv_q;

	// output register
	logic          m_tvalid_q;
	logic [DW-1:0] out_root_q;
	logic [SW-1:0] out_steps_q;
	logic          out_conv_q;

	// shared unit hookup
	logic          mul_start;
	logic [WW-1:0] mul_a;
	logic [WW-1:0] mul_c;
	logic          mul_done;
	logic [WW-1:0] mul_p;
	logic          div_start;
	logic          div_done;
	logic [QW-1:0] div_quo;

	// sequencer strobes
	logic in_take;
	logic out_load;
	logic x1_load;
	logic upd_take;

	// step arithmetic
	logic [WW-1:0]     x_ext;
	logic              n_neg;
	logic [WW-1:0]     n_mag;
	logic [QW-2:0]     corr_mag;
	logic [CORR_W-1:0] corr;
	logic [DIFF_W-1:0] diff;
	logic [DW-1:0]     x1_sat;
	logic [DW:0]       err;
	logic [DW:0]       err_abs;
	logic              conv_now;
	logic [SW-1:0]     steps_nx;
	logic              cfg_wr;

	assign x_ext = {{(WW-DW){x_q[DW-1]}}, x_q};
	assign n_neg = n_q[WW-1];
	assign n_mag = n_neg ? (WW'(0) - n_q) : n_q;

	// correction f/f', clamped to 2^40 in magnitude, then x - corr saturated to the word range
	always_comb begin
		corr_mag = (div_quo > ncrf_pkg::CORR_LIM) ? ncrf_pkg::CORR_LIM[QW-2:0] : div_quo[QW-2:0];
		corr     = n_neg ? (CORR_W'(0) - {1'b0, corr_mag}) : {1'b0, corr_mag};
		diff     = {{(DIFF_W-DW){x_q[DW-1]}}, x_q} - {corr[CORR_W-1], corr};
		if (!diff[DIFF_W-1] && (|diff[DIFF_W-2:DW-1])) begin
			x1_sat = {1'b0, {(DW-1){1'b1}}};
		end else if (diff[DIFF_W-1] && !(&diff[DIFF_W-2:DW-1])) begin
			x1_sat = {1'b1, {(DW-1){1'b0}}};
		end else begin
			x1_sat = diff[DW-1:0];
		end
	end

	// step size measured from the saturated estimate
	assign err      = {x1_q[DW-1], x1_q} - {x_q[DW-1], x_q};
	assign err_abs  = err[DW] ? ((DW+1)'(0) - err) : err;
	assign conv_now = err_abs <= {2'b00, tol_q};
	assign steps_nx = steps_q + 1'b1;

	// sequencer: next state and unit operand selection
	always_comb begin
		state_nx  = state_q;
		mul_start = 1'b0;
		mul_a     = '0;
		mul_c     = '0;
		div_start = 1'b0;
		in_take   = 1'b0;
		out_load  = 1'b0;
		x1_load   = 1'b0;
		upd_take  = 1'b0;
		case (state_q)
			ncrf_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					in_take  = 1'b1;
					// a zero limit hands the start point straight back
					state_nx = (limit_q == '0) ? ncrf_pkg::ST_DONE : ncrf_pkg::ST_STEP;
				end
			end
			ncrf_pkg::ST_STEP: begin
				// t = (x + 2s) * x + 10s^2
				mul_start = 1'b1;
				mul_a     = x_ext + K_T_LIN;
				mul_c     = K_T_CONST;
				state_nx  = ncrf_pkg::ST_MUL_T;
			end
			ncrf_pkg::ST_MUL_T: begin
				// n = t * x - 20s^3
				mul_a = mul_p;
				mul_c = K_N_CONST;
				if (mul_done) begin
					mul_start = 1'b1;
					state_nx  = ncrf_pkg::ST_MUL_N;
				end
			end
			ncrf_pkg::ST_MUL_N: begin
				// d = (3x + 4s) * x + 10s^2
				mul_a = (x_ext << 1) + x_ext + K_D_LIN;
				mul_c = K_D_CONST;
				if (mul_done) begin
					mul_start = 1'b1;
					state_nx  = ncrf_pkg::ST_MUL_D;
				end
			end
			ncrf_pkg::ST_MUL_D: begin
				if (mul_done) begin
					div_start = 1'b1;
					state_nx  = ncrf_pkg::ST_DIV;
				end
			end
			ncrf_pkg::ST_DIV: begin
				if (div_done) begin
					x1_load  = 1'b1;
					state_nx = ncrf_pkg::ST_UPDATE;
				end
			end
			ncrf_pkg::ST_UPDATE: begin
				upd_take = 1'b1;
				if (conv_now || (steps_nx == limit_q)) begin
					state_nx = ncrf_pkg::ST_DONE;
				end else begin
					state_nx = ncrf_pkg::ST_STEP;
				end
			end
			ncrf_pkg::ST_DONE: begin
				// hand over once the output register is free
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_nx = ncrf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = ncrf_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ncrf_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// control: step count, convergence, output valid, registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q    <= '0;
			conv_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
			tol_q      <= ncrf_pkg::TOLERANCE_RESET;
			limit_q    <= ncrf_pkg::LIMIT_RESET;
		end else begin
			if (in_take) begin
				steps_q <= '0;
				conv_q  <= 1'b0;
			end else if (upd_take) begin
				steps_q <= steps_nx;
				conv_q  <= conv_now;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_wr) begin
				case (paddr[2])
					ncrf_pkg::REG_TOLERANCE:  tol_q   <= pwdata[TW-1:0];
					ncrf_pkg::REG_ITER_LIMIT: limit_q <= pwdata[SW-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			x_q <= s_tdata[DW-1:0];
		end else if (upd_take) begin
			x_q <= x1_q;
		end
		if (x1_load) begin
			x1_q <= x1_sat;
		end
		if (mul_done && (state_q == ncrf_pkg::ST_MUL_N)) begin
			n_q <= mul_p;
		end
		if (out_load) begin
			out_root_q  <= x_q;
			out_steps_q <= steps_q;
			out_conv_q  <= conv_q;
		end
	end

	// shared multiply-accumulate unit
	ncrf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.x      (x_q),
		.c      (mul_c),
		.done   (mul_done),
		.p      (mul_p)
	);

	// divider, |n| by d, d taken from the multiplier as it finishes
	ncrf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (n_mag),
		.den    (mul_p),
		.done   (div_done),
		.quo    (div_quo)
	);

	// configuration port, decoded on the word address bit only
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (paddr[2])
			ncrf_pkg::REG_TOLERANCE:  prdata = {{(ncrf_pkg::APB_DATA_W-TW){1'b0}}, tol_q};
			ncrf_pkg::REG_ITER_LIMIT: prdata = {{(ncrf_pkg::APB_DATA_W-SW){1'b0}}, limit_q};
			default:                  prdata = '0;
		endcase
	end

	// stream ports
	assign s_tready = (state_q == ncrf_pkg::ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_steps_q, out_root_q};
	assign m_tuser  = out_conv_q;

	// a converged result always has at least one step behind it
	a_conv_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && out_conv_q) |-> (out_steps_q != '0))
		else $error("converged result with zero steps");

	// the divider starts only on the derivative product
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (mul_done && (state_q == ncrf_pkg::ST_MUL_D)))
		else $error("divider started without derivative");

	// the multiplier only finishes while the sequencer waits on it
	a_mul_done: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ncrf_pkg::ST_MUL_T || state_q == ncrf_pkg::ST_MUL_N ||
			state_q == ncrf_pkg::ST_MUL_D))
		else $error("multiplier done outside a wait state");

	// no step runs past the limit
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ncrf_pkg::ST_UPDATE) |-> (steps_q < limit_q))
		else $error("step count beyond iteration limit");

endmodule

`default_nettype wire

// ----- design/ncrf_mul.sv -----
// limb-serial multiply-accumulate: p = a * x + c, modulo 2^128
`default_nettype none

module ncrf_mul (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	input  wire  [ncrf_pkg::WIDE_W-1:0]     a,
	input  wire  [ncrf_pkg::DATA_W-1:0]     x,
	input  wire  [ncrf_pkg::WIDE_W-1:0]     c,
	output logic                            done,
	output logic [ncrf_pkg::WIDE_W-1:0]     p
);

	localparam int unsigned PROD_W = 2 * ncrf_pkg::LIMB_W;
	localparam logic [ncrf_pkg::LIMB_IDX_W-1:0] LAST_LIMB =
		ncrf_pkg::LIMB_IDX_W'(ncrf_pkg::LIMBS - 1);

	logic [ncrf_pkg::WIDE_W-1:0]     a_q;
	logic [ncrf_pkg::DATA_W-1:0]     x_q;
	logic [ncrf_pkg::WIDE_W-1:0]     acc_q;
	logic [ncrf_pkg::LIMB_IDX_W-1:0] limb_q;
	logic                            issue_q;
	logic                            done_q;
	logic [PROD_W-1:0]               prod_s1;
	logic [ncrf_pkg::LIMB_IDX_W-1:0] limb_s1;
	logic                            vld_s1;

	logic signed [ncrf_pkg::LIMB_W:0]   op_a;
	logic signed [ncrf_pkg::DATA_W:0]   op_x;
	logic signed [PROD_W+1:0]           prod_full;
	logic [ncrf_pkg::WIDE_W-1:0]        prod_ext;

	always_comb begin
		op_a      = $signed({1'b0, a_q[limb_q*ncrf_pkg::LIMB_W +: ncrf_pkg::LIMB_W]});
		op_x      = $signed({x_q[ncrf_pkg::DATA_W-1], x_q});
		prod_full = op_a * op_x;
		prod_ext  = {{(ncrf_pkg::WIDE_W-PROD_W){prod_s1[PROD_W-1]}}, prod_s1}
			<< {limb_s1, 5'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			vld_s1  <= 1'b0;
			done_q  <= 1'b0;
			limb_q  <= '0;
		end else begin
			done_q <= vld_s1 && (limb_s1 == LAST_LIMB);
			vld_s1 <= issue_q;
			if (start) begin
				issue_q <= 1'b1;
				limb_q  <= '0;
			end else if (issue_q) begin
				limb_q <= limb_q + 1'b1;
				if (limb_q == LAST_LIMB) begin
					issue_q <= 1'b0;
				end
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			x_q   <= x;
			acc_q <= c;
		end else if (vld_s1) begin
			acc_q <= acc_q + prod_ext;
		end
		prod_s1 <= prod_full[PROD_W-1:0];
		limb_s1 <= limb_q;
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule

`default_nettype wire

// ----- design/ncrf_div.sv -----
// restoring divider, one quotient bit a cycle, quotient bounded to QUO_W bits
`default_nettype none

module ncrf_div (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	input  wire  [ncrf_pkg::WIDE_W-1:0]     num,
	input  wire  [ncrf_pkg::WIDE_W-1:0]     den,
	output logic                            done,
	output logic [ncrf_pkg::QUO_W-1:0]      quo
);

	logic [ncrf_pkg::WIDE_W-1:0] rem_q;
	logic [ncrf_pkg::WIDE_W-1:0] dsh_q;
	logic [ncrf_pkg::QUO_W-1:0]  quo_q;
	logic [ncrf_pkg::CNT_W-1:0]  cnt_q;
	logic                        run_q;
	logic                        done_q;
	logic                        fits;

	assign fits = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == '0);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= ncrf_pkg::CNT_W'(ncrf_pkg::QUO_W - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// a quotient at or above 2^(QUO_W-1) only needs its top bit right, it is clamped
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= den << (ncrf_pkg::QUO_W - 1);
			quo_q <= '0;
		end else if (run_q) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[ncrf_pkg::QUO_W-2:0], fits};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// self-checking testbench for the newton cubic root finder core
`timescale 1ns / 100ps

module tb;
	import ncrf_pkg::*;

	localparam int unsigned FRAC           = FRAC_BITS_DEF;
	localparam int unsigned CYCLE_LIMIT    = 8_000_000;
	localparam int unsigned RX_HOLD_CYCLES = 4000;
	localparam int unsigned IDLE_PCT       = 29;
	localparam int unsigned RAND_PHASES    = 6;
	localparam int unsigned PHASE_WORDS    = 45;

	// start point close to the real root, about 1.3688 in q16.16
	localparam logic [DATA_W-1:0] ROOT_NEAR = 32'h0001_5E69;

	// register byte addresses, one 32-bit slot per register
	localparam logic [APB_ADDR_W-1:0] ADDR_TOLERANCE  = {REG_TOLERANCE, 2'b00};
	localparam logic [APB_ADDR_W-1:0] ADDR_ITER_LIMIT = {REG_ITER_LIMIT, 2'b00};

	// one result word as it should leave the block
	typedef struct packed {
		logic signed [DATA_W-1:0] root;
		logic [STEPS_W-1:0]       steps;
		logic                     conv;
	} root_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [S_TDATA_W-1:0]    s_tdata;
	logic                    m_tvalid;
	logic                    m_tready;
	logic [M_TDATA_W-1:0]    m_tdata;
	logic                    m_tuser;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [APB_ADDR_W-1:0]   paddr;
	logic [APB_DATA_W-1:0]   pwdata;
	logic [APB_DATA_W-1:0]   prdata;
	logic                    pready;

	// our own copy of the two registers
	logic [TOL_W-1:0]        tol_cfg;
	logic [STEPS_W-1:0]      lim_cfg;

	// results still owed by the block, oldest first
	root_result_t            pending_roots[$];

	int                      errors       = 0;
	int                      results_seen = 0;
	int                      conv_seen    = 0;
	int                      longest_run  = 0;
	int                      cfg_writes   = 0;
	int                      cycle_cnt    = 0;
	int                      hold_req     = 0;
	int                      hold_done    = 0;
	bit                      tx_idle_en;
	bit                      rx_idle_en;

	newton_cubic_root_finder_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #6 clk = ~clk;

	// one newton step in exact wide integers: N and D are the scaled f and f',
	// the correction is |N|/D truncated, clamped, then the new estimate saturates
	function automatic logic signed [DATA_W-1:0] newton_next(input logic signed [DATA_W-1:0] x);
		logic [WIDE_W-1:0]  xw;
		logic [WIDE_W-1:0]  sc;
		logic [WIDE_W-1:0]  num;
		logic [WIDE_W-1:0]  den;
		logic [WIDE_W-1:0]  qmag;
		logic               neg;
		logic signed [63:0] corr;
		logic signed [63:0] nx;
		xw  = WIDE_W'(x);
		sc  = WIDE_W'(1) << FRAC;
		// ring arithmetic mod 2^128 keeps two's complement bit patterns exact
		num = xw * xw * xw
			+ WIDE_W'(CUBIC_SQ_COEF) * xw * xw * sc
			+ WIDE_W'(CUBIC_LIN_COEF) * xw * sc * sc
			- WIDE_W'(CUBIC_CONST) * sc * sc * sc;
		den = WIDE_W'(DERIV_SQ_COEF) * xw * xw
			+ WIDE_W'(DERIV_LIN_COEF) * xw * sc
			+ WIDE_W'(DERIV_CONST) * sc * sc;
		neg = num[WIDE_W-1];
		if (neg) begin
			num = -num;
		end
		// derivative is strictly positive, so den is never zero
		qmag = num / den;
		if (qmag > (WIDE_W'(1) << CORR_LOG2)) begin
			corr = 64'sd1 <<< CORR_LOG2;
		end else begin
			corr = $signed(qmag[63:0]);
		end
		if (neg) begin
			corr = -corr;
		end
		nx = 64'(x) - corr;
		if (nx > 64'sd2147483647) begin
			nx = 64'sd2147483647;
		end
		if (nx < -64'sd2147483648) begin
			nx = -64'sd2147483648;
		end
		return nx[DATA_W-1:0];
	endfunction

	// full search from one start point under the current register values
	function automatic root_result_t solve_cubic(input logic signed [DATA_W-1:0] x0);
		root_result_t             r;
		logic signed [DATA_W-1:0] cur;
		logic signed [DATA_W-1:0] nxt;
		logic [DATA_W:0]          gap;
		int                       i;
		cur     = x0;
		r.root  = x0;
		r.steps = '0;
		r.conv  = 1'b0;
		for (i = 1; i <= int'(lim_cfg); i++) begin
			nxt     = newton_next(cur);
			r.root  = nxt;
			r.steps = STEPS_W'(i);
			// distance is taken from the saturated value
			gap = {nxt[DATA_W-1], nxt} - {cur[DATA_W-1], cur};
			if (gap[DATA_W]) begin
				gap = -gap;
			end
			if (gap <= {2'b00, tol_cfg}) begin
				r.conv = 1'b1;
				break;
			end
			cur = nxt;
		end
		return r;
	endfunction

	// mix of start points: anywhere, small magnitudes, near the root, random scale
	function automatic logic [DATA_W-1:0] pick_start();
		case ($urandom_range(3))
			0: begin
				return $urandom;
			end
			1: begin
				return DATA_W'($urandom_range(32'h000F_FFFF)) - 32'h0008_0000;
			end
			2: begin
				return ROOT_NEAR + DATA_W'($urandom_range(2047)) - 32'd1024;
			end
			default: begin
				return DATA_W'($signed($urandom) >>> $urandom_range(31, 0));
			end
		endcase
	endfunction

	// cycle budget, far above the slowest legal run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// result side: random stalls, or one long hold-off counted here on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != hold_done) begin
				m_tready = 1'b0;
				repeat (RX_HOLD_CYCLES) @(negedge clk);
				hold_done = hold_done + 1;
			end
			m_tready = rx_idle_en ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
		end
	end

	// every accepted result word is compared with the oldest prediction
	always @(posedge clk) begin
		root_result_t want;
		if (m_tvalid === 1'b1 && m_tready) begin
			if (pending_roots.size() == 0) begin
				errors++;
				$error("result word with no prediction waiting: tdata %h tuser %b",
					m_tdata, m_tuser);
			end else begin
				want = pending_roots.pop_front();
				results_seen++;
				if (m_tdata[31:0] !== want.root) begin
					errors++;
					$error("root_estimate: expected %h, got %h", want.root, m_tdata[31:0]);
				end
				if (m_tdata[39:32] !== want.steps) begin
					errors++;
					$error("steps_taken: expected %0d, got %0d", want.steps, m_tdata[39:32]);
				end
				if (m_tuser !== want.conv) begin
					errors++;
					$error("converged: expected %b, got %b", want.conv, m_tuser);
				end
				if (want.conv) begin
					conv_seen++;
				end
				if (int'(want.steps) > longest_run) begin
					longest_run = int'(want.steps);
				end
			end
		end
	end

	// offer one start point, with random gaps unless idling is off,
	// and predict its result once the block takes it
	task automatic send_word(input logic [DATA_W-1:0] start);
		@(negedge clk);
		while (tx_idle_en && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = start;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_roots.push_back(solve_cubic(start));
	endtask

	// stop offering and wait until every predicted result has been taken
	task automatic wait_results();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_roots.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// read a register back and compare with our copy
	task automatic check_reg(input logic [APB_ADDR_W-1:0] addr);
		logic [APB_DATA_W-1:0] want;
		logic [APB_DATA_W-1:0] got;
		want = (addr == ADDR_TOLERANCE) ? APB_DATA_W'(tol_cfg) : APB_DATA_W'(lim_cfg);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = addr;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		got = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		if (got !== want) begin
			errors++;
			$error("register at %0d: expected %h, got %h", addr, want, got);
		end
	endtask

	// setup then access phase; our copy follows at the write edge
	task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = addr;
		pwdata  = data;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (addr == ADDR_TOLERANCE) begin
			tol_cfg = data[TOL_W-1:0];
		end else begin
			lim_cfg = data[STEPS_W-1:0];
		end
		cfg_writes++;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		check_reg(addr);
	endtask

	task automatic test_reset_values();
		check_reg(ADDR_TOLERANCE);
		check_reg(ADDR_ITER_LIMIT);
	endtask

	// field extremes and points of interest under the reset settings
	task automatic test_directed_points();
		logic [DATA_W-1:0] pts[12];
		pts = '{32'h0000_0000, 32'h0001_0000, ROOT_NEAR, 32'h7FFF_FFFF,
			32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_0000,
			32'hFFFF_5556, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0014_0000};
		foreach (pts[i]) begin
			send_word(pts[i]);
		end
		wait_results();
	endtask

	// full-scale tolerance, zero tolerance, single step and longest limit
	task automatic test_register_extremes();
		write_reg(ADDR_TOLERANCE, 32'h7FFF_FFFF);
		write_reg(ADDR_ITER_LIMIT, 32'd255);
		send_word(32'h7FFF_FFFF);
		send_word(32'h8000_0000);
		wait_results();
		write_reg(ADDR_TOLERANCE, 32'h0000_0000);
		write_reg(ADDR_ITER_LIMIT, 32'd1);
		send_word(32'h1234_5678);
		send_word(32'hEDCB_A988);
		wait_results();
		// exact convergence demanded, so a search may run to the full limit
		write_reg(ADDR_ITER_LIMIT, 32'd255);
		send_word(ROOT_NEAR);
		send_word(32'h4000_0000);
		wait_results();
	endtask

	// limit of zero: no step, the start point comes straight back unconverged
	task automatic test_zero_limit();
		write_reg(ADDR_TOLERANCE, APB_DATA_W'(TOLERANCE_RESET));
		write_reg(ADDR_ITER_LIMIT, 32'd0);
		send_word(32'h0001_0000);
		send_word(32'h8000_0000);
		wait_results();
	endtask

	// result side holds off long enough for the block to fill and refuse input
	task automatic test_backpressure();
		int n;
		write_reg(ADDR_ITER_LIMIT, 32'd20);
		tx_idle_en = 1'b0;
		hold_req   = hold_req + 1;
		for (n = 0; n < 6; n++) begin
			send_word(pick_start());
		end
		// sender pauses here until all results are back
		wait_results();
		tx_idle_en = 1'b1;
	endtask

	// random start points over several register settings; the first phase
	// runs with no idling on either side
	task automatic test_random_items();
		int                 phase;
		int                 n;
		logic [TOL_W-1:0]   tol;
		logic [STEPS_W-1:0] lim;
		for (phase = 0; phase < RAND_PHASES; phase++) begin
			wait_results();
			tx_idle_en = (phase != 0);
			rx_idle_en = (phase != 0);
			lim = STEPS_W'($urandom_range(64, 1));
			case (phase)
				0: begin
					tol = TOLERANCE_RESET;
					lim = LIMIT_RESET;
				end
				1: begin
					tol = '0;
					lim = STEPS_W'($urandom_range(24, 1));
				end
				2: begin
					tol = TOL_W'($urandom_range(255));
				end
				default: begin
					tol = TOL_W'($urandom >> $urandom_range(31, 1));
				end
			endcase
			write_reg(ADDR_TOLERANCE, APB_DATA_W'(tol));
			write_reg(ADDR_ITER_LIMIT, APB_DATA_W'(lim));
			for (n = 0; n < PHASE_WORDS; n++) begin
				send_word(pick_start());
			end
		end
		wait_results();
	endtask

	initial begin
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		tol_cfg    = TOLERANCE_RESET;
		lim_cfg    = LIMIT_RESET;
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_values();
		test_directed_points();
		test_register_extremes();
		test_zero_limit();
		test_backpressure();
		test_random_items();

		// let any late word show up before the verdict
		repeat (100) @(posedge clk);
		if (pending_roots.size() != 0) begin
			errors++;
			$error("%0d predicted results never arrived", pending_roots.size());
		end

		$display("checked %0d result words over %0d register writes: %0d converged, %0d stopped at the limit",
			results_seen, cfg_writes, conv_seen, results_seen - conv_seen);
		$display("longest search %0d steps; tolerance from zero to full scale, limit from 0 to 255",
			longest_run);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
